@@ src/mqp_pkg.sv @@
// Package for the multi-queue priority message store.
// Holds the item structs, opcode and status codes, and the cell control struct.
package mqp_pkg;

	localparam logic OP_SEND    = 1'b0;
	localparam logic OP_RECEIVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  queue_id;
		logic [7:0]  priority_req;
		logic [31:0] payload;
		logic [7:0]  length;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_priority;
		logic [31:0] out_payload;
		logic [7:0]  out_length;
	} rsp_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic       wr_en;
		logic       is_send;
		logic [7:0] prio;
	} cell_ctl_t;

endpackage

@@ src/mqp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mqp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/mqp_cell.sv @@
// One slot position of every queue: a small RAM indexed by queue plus the
// insert and shift logic. Depends on mqp_pkg and mqp_ram.
module mqp_cell #(
	parameter int NUM_QUEUES = 8,
	parameter int EW         = 48,
	parameter int QW         = 3
) (
	input  logic              clk,
	input  logic [QW-1:0]     qidx,
	input  mqp_pkg::cell_ctl_t ctl,
	input  logic [EW-1:0]     new_entry,
	input  logic              slot_valid,
	input  logic              left_ge,
	input  logic [EW-1:0]     left_data,
	input  logic [EW-1:0]     right_data,
	output logic [EW-1:0]     own_data,
	output logic              own_ge
);
	logic [EW-1:0] next_data;

	mqp_ram #(.WIDTH(EW), .DEPTH(NUM_QUEUES)) u_ram (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (qidx),
		.wdata (next_data),
		.raddr (qidx),
		.rdata (own_data)
	);

	// The priority sits in the top byte of an entry. Entries at or above the
	// new priority stay; the first one below it takes the new entry and the
	// rest take their left neighbor. A receive takes the right neighbor.
	always_comb begin
		own_ge = slot_valid && (own_data[EW-1 -: 8] >= ctl.prio);
		if (!ctl.is_send) begin
			next_data = right_data;
		end else if (own_ge) begin
			next_data = own_data;
		end else if (left_ge) begin
			next_data = new_entry;
		end else begin
			next_data = left_data;
		end
	end
endmodule

@@ src/multi_queue_priority_message_store_top.sv @@
// Top level of the multi-queue priority message store.
// Depends on mqp_pkg, mqp_cell and mqp_ram.
// An accepted item is read from the cell RAMs in the next cycle and updated and
// written back in the cycle after that, where its result is registered; the
// result is then offered and waits there until it is taken. A new item is taken
// only once the previous result has left. The row of QUEUE_DEPTH cells holds
// slot i of every queue in cell i, so a sorted insert or a head removal updates
// all slots of one queue at once, each cell passing its entry to its neighbor.
// A send to a full or nonexistent queue reports full, a receive from an empty
// or nonexistent queue reports empty; data fields are zero unless a receive
// succeeds.
module multi_queue_priority_message_store_top #(
	parameter int NUM_QUEUES   = 8,
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mqp_pkg::req_t in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output mqp_pkg::rsp_t out_item
);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = 16 + PAYLOAD_BITS;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_WR   = 3'b100
	} state_t;

	state_t             state_q;
	mqp_pkg::req_t      req_q;
	mqp_pkg::rsp_t      rsp_q;
	logic               out_valid_q;
	logic [CW-1:0]      count_q [NUM_QUEUES];

	logic [QW-1:0]      qidx;
	logic               q_ok;
	logic [CW-1:0]      cnt;
	logic               send_ok;
	logic               recv_ok;
	logic               op_ok;
	logic [63:0]        pay_wide;
	logic [EW-1:0]      new_entry;
	mqp_pkg::cell_ctl_t ctl;
	logic [EW-1:0]      cell_data [QUEUE_DEPTH];
	logic               cell_ge   [QUEUE_DEPTH];
	logic [63:0]        head_wide;

	// Request decode against the queue's fill count.
	always_comb begin
		qidx     = QW'(req_q.queue_id);
		q_ok     = 32'(req_q.queue_id) < NUM_QUEUES;
		cnt      = count_q[qidx];
		send_ok  = q_ok && (cnt < CW'(QUEUE_DEPTH));
		recv_ok  = q_ok && (cnt != '0);
		op_ok    = (req_q.opcode == mqp_pkg::OP_SEND) ? send_ok : recv_ok;
		pay_wide = 64'(req_q.payload);
		new_entry = {req_q.priority_req, pay_wide[PAYLOAD_BITS-1:0], req_q.length};
		ctl.wr_en   = (state_q == S_WR) && op_ok;
		ctl.is_send = (req_q.opcode == mqp_pkg::OP_SEND);
		ctl.prio    = req_q.priority_req;
		head_wide   = 64'(cell_data[0][EW-9:8]);
	end

	// The chain of slot cells.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic          lge;
		logic [EW-1:0] ldat;
		logic [EW-1:0] rdat;
		if (i == 0) begin : g_first
			assign lge  = 1'b1;
			assign ldat = '0;
		end else begin : g_mid
			assign lge  = cell_ge[i-1];
			assign ldat = cell_data[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rdat = '0;
		end else begin : g_inner
			assign rdat = cell_data[i+1];
		end
		mqp_cell #(.NUM_QUEUES(NUM_QUEUES), .EW(EW), .QW(QW)) u_cell (
			.clk        (clk),
			.qidx       (qidx),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.slot_valid (cnt > CW'(i)),
			.left_ge    (lge),
			.left_data  (ldat),
			.right_data (rdat),
			.own_data   (cell_data[i]),
			.own_ge     (cell_ge[i])
		);
	end

	// Sequencer, fill counts and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_QUEUES; k++) begin
				count_q[k] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					if (op_ok) begin
						if (ctl.is_send) begin
							count_q[qidx] <= cnt + CW'(1);
						end else begin
							count_q[qidx] <= cnt - CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_item;
		end
		if (state_q == S_WR) begin
			if (ctl.is_send) begin
				rsp_q.status       <= send_ok ? mqp_pkg::ST_OK : mqp_pkg::ST_FULL;
				rsp_q.out_priority <= '0;
				rsp_q.out_payload  <= '0;
				rsp_q.out_length   <= '0;
			end else if (recv_ok) begin
				rsp_q.status       <= mqp_pkg::ST_OK;
				rsp_q.out_priority <= cell_data[0][EW-1 -: 8];
				rsp_q.out_payload  <= head_wide[31:0];
				rsp_q.out_length   <= cell_data[0][7:0];
			end else begin
				rsp_q.status       <= mqp_pkg::ST_EMPTY;
				rsp_q.out_priority <= '0;
				rsp_q.out_payload  <= '0;
				rsp_q.out_length   <= '0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = rsp_q;
endmodule

@@ src/mqp_checker.sv @@
// Port-level checker for the multi-queue priority message store, with its bind.
// Depends on mqp_pkg and the top level's ports.
module mqp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input mqp_pkg::req_t in_item,
	input logic          out_valid,
	input logic          out_ready,
	input mqp_pkg::rsp_t out_item
);
	// A result never carries the unused status code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.status != 2'd3))
		else $error("unused status code");

	// Data fields are zero unless the result is a successful receive.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status != mqp_pkg::ST_OK) |->
		(out_item.out_priority == '0 && out_item.out_payload == '0 &&
		 out_item.out_length == '0))
		else $error("nonzero data on failed operation");

	// One item at a time: no new item right after one is taken.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while busy");

	// A waiting result stays until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("result dropped or changed while stalled");
endmodule

bind multi_queue_priority_message_store_top mqp_checker u_mqp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
